// ===== rtl/core/fcs_pkg.sv =====
`default_nettype none

package fcs_pkg;

    localparam int MAX_LEN     = 1024;
    localparam int SAMPLE_BITS = 16;
    localparam int FRAC_BITS   = 16;
    localparam int ADDR_BITS   = $clog2(MAX_LEN);
    localparam int LEN_BITS    = ADDR_BITS + 1;
    localparam int SHIFT_BITS  = 11;
    localparam int VALUE_BITS  = 32;
    localparam int POS_BITS    = 10;
    localparam int STEP_BITS   = $clog2(SHIFT_BITS);
    localparam int PROD_BITS   = SAMPLE_BITS + FRAC_BITS + 2;

    localparam int CFG_INDEX_BITS = 1;
    localparam int CFG_DATA_BITS  = 16;

    localparam logic [CFG_INDEX_BITS-1:0] CFG_SHIFT_WHOLE = 1'b0;
    localparam logic [CFG_INDEX_BITS-1:0] CFG_SHIFT_FRAC  = 1'b1;

    localparam logic REQ_LOAD   = 1'b0;
    localparam logic REQ_OUTPUT = 1'b1;

    typedef struct packed {
        logic                   req_type;
        logic [SAMPLE_BITS-1:0] sample;
        logic                   last_sample;
    } req_t;

    typedef struct packed {
        logic [VALUE_BITS-1:0] value;
        logic [POS_BITS-1:0]   position;
        logic                  last_output;
    } result_t;

    typedef enum logic [2:0] {
        ST_IDLE,
        ST_DIV,
        ST_FIX,
        ST_IDX,
        ST_RD0,
        ST_RD1,
        ST_MUL,
        ST_SUM
    } state_t;

    typedef struct packed {
        logic load;
        logic open_out;
        logic div_step;
        logic fix;
        logic idx;
        logic rd0;
        logic rd1;
        logic mul;
        logic emit;
    } dp_cmd_t;

    typedef struct packed {
        logic has_curve;
    } dp_status_t;

endpackage

`default_nettype wire

// ===== rtl/core/fcs_ram.sv =====
`default_nettype none

module fcs_ram #(
    parameter int WIDTH = 16,
    parameter int DEPTH = 1024
) (
    input  wire logic                     clk,
    input  wire logic                     we,
    input  wire logic [$clog2(DEPTH)-1:0] waddr,
    input  wire logic [WIDTH-1:0]         wdata,
    input  wire logic [$clog2(DEPTH)-1:0] raddr,
    output logic      [WIDTH-1:0]         rdata
);

    logic [WIDTH-1:0] mem [DEPTH];

    always_ff @(posedge clk)
    begin
        if (we)
        begin
            mem[waddr] <= wdata;
        end
        rdata <= mem[raddr];
    end

endmodule

`default_nettype wire

// ===== rtl/core/fcs_ctrl.sv =====
`default_nettype none

module fcs_ctrl (
    input  wire logic               clk,
    input  wire logic               rst_n,
    input  wire logic               start,
    input  wire logic               req_type,
    input  wire fcs_pkg::dp_status_t status,
    output logic                    busy,
    output fcs_pkg::dp_cmd_t        cmd
);

    import fcs_pkg::*;

    state_t                 state_reg;
    state_t                 state_next;
    logic [STEP_BITS-1:0]   cnt_reg;
    logic [STEP_BITS-1:0]   cnt_next;

    always_ff @(posedge clk or negedge rst_n)
    begin
        if (!rst_n)
        begin
            state_reg <= ST_IDLE;
            cnt_reg   <= '0;
        end
        else
        begin
            state_reg <= state_next;
            cnt_reg   <= cnt_next;
        end
    end

    always_comb
    begin
        state_next = state_reg;
        cnt_next   = cnt_reg;
        cmd        = '0;
        unique case (state_reg)
            ST_IDLE:
            begin
                if (start)
                begin
                    if (req_type == REQ_LOAD)
                    begin
                        cmd.load = 1'b1;
                    end
                    else if (status.has_curve)
                    begin
                        cmd.open_out = 1'b1;
                        cnt_next     = STEP_BITS'(SHIFT_BITS - 1);
                        state_next   = ST_DIV;
                    end
                end
            end
            ST_DIV:
            begin
                cmd.div_step = 1'b1;
                if (cnt_reg == '0)
                begin
                    state_next = ST_FIX;
                end
                else
                begin
                    cnt_next = cnt_reg - STEP_BITS'(1);
                end
            end
            ST_FIX:
            begin
                cmd.fix    = 1'b1;
                state_next = ST_IDX;
            end
            ST_IDX:
            begin
                cmd.idx    = 1'b1;
                state_next = ST_RD0;
            end
            ST_RD0:
            begin
                cmd.rd0    = 1'b1;
                state_next = ST_RD1;
            end
            ST_RD1:
            begin
                cmd.rd1    = 1'b1;
                state_next = ST_MUL;
            end
            ST_MUL:
            begin
                cmd.mul    = 1'b1;
                state_next = ST_SUM;
            end
            ST_SUM:
            begin
                cmd.emit   = 1'b1;
                state_next = ST_IDLE;
            end
            default:
            begin
                state_next = ST_IDLE;
            end
        endcase
    end

    assign busy = (state_reg != ST_IDLE);

endmodule

`default_nettype wire

// ===== rtl/core/fcs_datapath.sv =====
`default_nettype none

module fcs_datapath (
    input  wire logic                                clk,
    input  wire logic                                rst_n,
    input  wire fcs_pkg::dp_cmd_t                    cmd,
    input  wire fcs_pkg::req_t                       req,
    input  wire logic                                cfg_write,
    input  wire logic [fcs_pkg::CFG_INDEX_BITS-1:0]  cfg_index,
    input  wire logic [fcs_pkg::CFG_DATA_BITS-1:0]   cfg_data,
    output fcs_pkg::dp_status_t                      status,
    output logic                                     done,
    output fcs_pkg::result_t                         result
);

    import fcs_pkg::*;

    // configuration
    logic [SHIFT_BITS-1:0]  shift_whole_reg;
    logic [FRAC_BITS-1:0]   shift_frac_reg;

    // curve bookkeeping
    logic [ADDR_BITS-1:0]   load_count_reg;
    logic [LEN_BITS-1:0]    curve_length_reg;
    logic [ADDR_BITS-1:0]   emit_index_reg;
    logic                   done_reg;

    // per-output work registers
    logic [ADDR_BITS-1:0]   pos_reg;
    logic                   neg_reg;
    logic [SHIFT_BITS-1:0]  dividend_reg;
    logic [ADDR_BITS-1:0]   rem_reg;
    logic [ADDR_BITS-1:0]   k_reg;
    logic [ADDR_BITS-1:0]   i0_reg;
    logic [ADDR_BITS-1:0]   i1_reg;
    logic [SAMPLE_BITS-1:0] x0_reg;
    logic signed [PROD_BITS-1:0] prod_reg;
    result_t                result_reg;

    logic                   load_end;
    logic [ADDR_BITS-1:0]   pos_next;
    logic [SHIFT_BITS-1:0]  abs_shift;
    logic [ADDR_BITS:0]     trial;
    logic [ADDR_BITS-1:0]   rem_next;
    logic [LEN_BITS-1:0]    neg_rem;
    logic [ADDR_BITS-1:0]   k_next;
    logic [LEN_BITS-1:0]    idx_sum;
    logic [ADDR_BITS-1:0]   i0_next;
    logic [LEN_BITS-1:0]    idx_inc;
    logic [ADDR_BITS-1:0]   i1_next;
    logic [ADDR_BITS-1:0]   raddr;
    logic [SAMPLE_BITS-1:0] rdata;
    logic signed [SAMPLE_BITS:0] diff;
    logic signed [FRAC_BITS:0]   frac_s;
    logic [VALUE_BITS-1:0]  value_next;
    logic                   last_pos;

    always_ff @(posedge clk or negedge rst_n)
    begin
        if (!rst_n)
        begin
            shift_whole_reg <= '0;
            shift_frac_reg  <= '0;
        end
        else if (cfg_write)
        begin
            if (cfg_index == CFG_SHIFT_WHOLE)
            begin
                shift_whole_reg <= cfg_data[SHIFT_BITS-1:0];
            end
            else if (cfg_index == CFG_SHIFT_FRAC)
            begin
                shift_frac_reg <= cfg_data[FRAC_BITS-1:0];
            end
        end
    end

    assign load_end = req.last_sample || (load_count_reg == ADDR_BITS'(MAX_LEN - 1));
    assign last_pos = ({1'b0, pos_reg} == (curve_length_reg - LEN_BITS'(1)));
    assign pos_next = ({1'b0, emit_index_reg} >= curve_length_reg) ? '0 : emit_index_reg;

    always_ff @(posedge clk or negedge rst_n)
    begin
        if (!rst_n)
        begin
            load_count_reg   <= '0;
            curve_length_reg <= '0;
            emit_index_reg   <= '0;
            done_reg         <= 1'b0;
        end
        else
        begin
            done_reg <= cmd.emit;
            if (cmd.load)
            begin
                if (load_end)
                begin
                    curve_length_reg <= {1'b0, load_count_reg} + LEN_BITS'(1);
                    load_count_reg   <= '0;
                    emit_index_reg   <= '0;
                end
                else
                begin
                    load_count_reg <= load_count_reg + ADDR_BITS'(1);
                end
            end
            else if (cmd.emit)
            begin
                emit_index_reg <= last_pos ? '0 : pos_reg + ADDR_BITS'(1);
            end
        end
    end

    // floor modulo of the whole shift: restoring remainder, one bit a cycle
    assign abs_shift = shift_whole_reg[SHIFT_BITS-1] ? (~shift_whole_reg + SHIFT_BITS'(1))
                                                     : shift_whole_reg;
    assign trial     = {rem_reg, dividend_reg[SHIFT_BITS-1]};
    assign rem_next  = (trial >= curve_length_reg) ? ADDR_BITS'(trial - curve_length_reg)
                                                   : trial[ADDR_BITS-1:0];
    assign neg_rem   = curve_length_reg - {1'b0, rem_reg};
    assign k_next    = (neg_reg && (rem_reg != '0)) ? neg_rem[ADDR_BITS-1:0] : rem_reg;

    // tap addresses with wrap
    assign idx_sum = {1'b0, pos_reg} + {1'b0, k_reg};
    assign i0_next = (idx_sum >= curve_length_reg) ? ADDR_BITS'(idx_sum - curve_length_reg)
                                                   : idx_sum[ADDR_BITS-1:0];
    assign idx_inc = {1'b0, i0_reg} + LEN_BITS'(1);
    assign i1_next = (idx_inc >= curve_length_reg) ? '0 : idx_inc[ADDR_BITS-1:0];

    assign raddr = cmd.rd1 ? i1_reg : i0_reg;

    fcs_ram #(
        .WIDTH (SAMPLE_BITS),
        .DEPTH (MAX_LEN)
    ) u_store (
        .clk   (clk),
        .we    (cmd.load),
        .waddr (load_count_reg),
        .wdata (req.sample),
        .raddr (raddr),
        .rdata (rdata)
    );

    // x0*(1-f) + x1*f computed as x0*one + (x1-x0)*f
    assign diff       = $signed({1'b0, rdata}) - $signed({1'b0, x0_reg});
    assign frac_s     = $signed({1'b0, shift_frac_reg});
    assign value_next = VALUE_BITS'({x0_reg, {FRAC_BITS{1'b0}}})
                      + prod_reg[VALUE_BITS-1:0];

    always_ff @(posedge clk)
    begin
        if (cmd.open_out)
        begin
            pos_reg      <= pos_next;
            neg_reg      <= shift_whole_reg[SHIFT_BITS-1];
            dividend_reg <= abs_shift;
            rem_reg      <= '0;
        end
        if (cmd.div_step)
        begin
            rem_reg      <= rem_next;
            dividend_reg <= {dividend_reg[SHIFT_BITS-2:0], 1'b0};
        end
        if (cmd.fix)
        begin
            k_reg <= k_next;
        end
        if (cmd.idx)
        begin
            i0_reg <= i0_next;
        end
        if (cmd.rd0)
        begin
            i1_reg <= i1_next;
        end
        if (cmd.rd1)
        begin
            x0_reg <= rdata;
        end
        if (cmd.mul)
        begin
            prod_reg <= diff * frac_s;
        end
        if (cmd.emit)
        begin
            result_reg.value       <= value_next;
            result_reg.position    <= POS_BITS'(pos_reg);
            result_reg.last_output <= last_pos;
        end
    end

    assign status.has_curve = (curve_length_reg != '0);
    assign done             = done_reg;
    assign result           = result_reg;

endmodule

`default_nettype wire

// ===== rtl/core/fractional_circular_shift.sv =====
// fractional_circular_shift
// command port: an item is transferred at a clock edge with start high and busy low.
// req.req_type selects a load (store req.sample, req.last_sample ends the curve)
// or an output request (read the next sample of the shifted curve).
// a load completes in the transfer cycle and never raises busy; the next item
// may follow in the very next cycle.
// an output request raises busy while it computes the remainder of the whole
// shift by the curve length (one bit a cycle), folds the sign, forms the tap
// address, does the two reads through the single read port of the store, the
// multiply and the sum. done then pulses for one cycle with the result; the
// receiver cannot stall, and a new item may be transferred in that same cycle.
// output requests with no curve loaded return nothing and never raise busy.
// config: cfg_write with cfg_index/cfg_data writes shift_whole or shift_frac;
// write only while idle.
// reset clears the shift registers, load count, curve length and output index;
// the sample store is not cleared.
`default_nettype none

module fractional_circular_shift (
    input  wire logic                                clk,
    input  wire logic                                rst_n,
    input  wire logic                                start,
    output logic                                     busy,
    input  wire fcs_pkg::req_t                       req,
    output logic                                     done,
    output fcs_pkg::result_t                         result,
    input  wire logic                                cfg_write,
    input  wire logic [fcs_pkg::CFG_INDEX_BITS-1:0]  cfg_index,
    input  wire logic [fcs_pkg::CFG_DATA_BITS-1:0]   cfg_data
);

    import fcs_pkg::*;

    dp_cmd_t    cmd;
    dp_status_t status;

    fcs_ctrl u_ctrl (
        .clk      (clk),
        .rst_n    (rst_n),
        .start    (start),
        .req_type (req.req_type),
        .status   (status),
        .busy     (busy),
        .cmd      (cmd)
    );

    fcs_datapath u_datapath (
        .clk       (clk),
        .rst_n     (rst_n),
        .cmd       (cmd),
        .req       (req),
        .cfg_write (cfg_write),
        .cfg_index (cfg_index),
        .cfg_data  (cfg_data),
        .status    (status),
        .done      (done),
        .result    (result)
    );

    a_done_after_busy: assert property (@(posedge clk) disable iff (!rst_n)
        done |-> $past(busy))
        else $error("result strobe without a preceding busy cycle");

    a_done_single: assert property (@(posedge clk) disable iff (!rst_n)
        done |=> !done)
        else $error("result strobe longer than one cycle");

    a_load_no_busy: assert property (@(posedge clk) disable iff (!rst_n)
        (start && !busy && (req.req_type == REQ_LOAD)) |=> !busy)
        else $error("load transfer raised busy");

    a_busy_only_after_output: assert property (@(posedge clk) disable iff (!rst_n)
        $rose(busy) |-> $past(start && (req.req_type == REQ_OUTPUT)))
        else $error("busy rose without an output request");

endmodule

`default_nettype wire

// ===== sim/fcs_checker.sv =====
`timescale 1ns / 1ps

module fcs_checker (
    input  logic                                clk,
    input  logic                                rst_n,
    input  logic                                start,
    input  logic                                busy,
    input  fcs_pkg::req_t                       req,
    input  logic                                done,
    input  fcs_pkg::result_t                    result,
    input  logic                                cfg_write,
    input  logic [fcs_pkg::CFG_INDEX_BITS-1:0]  cfg_index,
    input  logic [fcs_pkg::CFG_DATA_BITS-1:0]   cfg_data,
    output int                                  fail_count,
    output int                                  pending_results
);

    import fcs_pkg::*;

    logic [SAMPLE_BITS-1:0]       curve_mem [0:MAX_LEN-1];
    int                           fill_count;
    int                           curve_len;
    int                           next_pos;
    logic signed [SHIFT_BITS-1:0] shift_whole_q;
    logic [FRAC_BITS-1:0]         shift_frac_q;
    result_t                      expected_samples [$];
    result_t                      oldest;
    int                           mismatches = 0;
    int                           waiting = 0;

    assign fail_count      = mismatches;
    assign pending_results = waiting;

    task automatic report_mismatch(input string what);
        $display("mismatch at %0t ns: %s", $realtime, what);
        mismatches++;
    endtask

    // advance the shifted-curve state by one transfer and queue its result, if any
    task automatic apply_request(input req_t item);
        int          span;
        int          whole;
        int          tap0;
        int          tap1;
        logic [63:0] mix;
        result_t     outcome;
        if (item.req_type == REQ_LOAD)
        begin
            if (fill_count < MAX_LEN)
                curve_mem[fill_count] = item.sample;
            if (item.last_sample || fill_count + 1 >= MAX_LEN)
            begin
                curve_len  = fill_count + 1;
                fill_count = 0;
                next_pos   = 0;
            end
            else
                fill_count++;
        end
        else if (curve_len != 0)
        begin
            span = curve_len;
            if (next_pos >= span)
                next_pos = 0;
            // floor modulo of the signed whole shift
            whole = shift_whole_q;
            whole = whole % span;
            if (whole < 0)
                whole += span;
            tap0 = next_pos + whole;
            if (tap0 >= span)
                tap0 -= span;
            tap1 = tap0 + 1;
            if (tap1 >= span)
                tap1 -= span;
            mix = 64'(curve_mem[tap0]) * ((64'd1 << FRAC_BITS) - 64'(shift_frac_q))
                + 64'(curve_mem[tap1]) * 64'(shift_frac_q);
            outcome.value       = mix[VALUE_BITS-1:0];
            outcome.position    = POS_BITS'(next_pos);
            outcome.last_output = (next_pos == span - 1);
            next_pos = outcome.last_output ? 0 : next_pos + 1;
            expected_samples.push_back(outcome);
        end
    endtask

    always @(posedge clk or negedge rst_n)
    begin
        if (!rst_n)
        begin
            fill_count    = 0;
            curve_len     = 0;
            next_pos      = 0;
            shift_whole_q = '0;
            shift_frac_q  = '0;
            expected_samples.delete();
            waiting = 0;
        end
        else
        begin
            if (done)
            begin
                if (expected_samples.size() == 0)
                    report_mismatch($sformatf("unexpected result at position %0d",
                                              result.position));
                else
                begin
                    oldest = expected_samples.pop_front();
                    if (result.value !== oldest.value)
                        report_mismatch($sformatf("value %h, expected %h (position %0d)",
                                                  result.value, oldest.value,
                                                  oldest.position));
                    if (result.position !== oldest.position)
                        report_mismatch($sformatf("position %0d, expected %0d",
                                                  result.position, oldest.position));
                    if (result.last_output !== oldest.last_output)
                        report_mismatch($sformatf("last_output %b, expected %b (position %0d)",
                                                  result.last_output, oldest.last_output,
                                                  oldest.position));
                end
            end
            if (cfg_write)
            begin
                if (cfg_index == CFG_SHIFT_WHOLE)
                    shift_whole_q = cfg_data[SHIFT_BITS-1:0];
                else if (cfg_index == CFG_SHIFT_FRAC)
                    shift_frac_q = cfg_data[FRAC_BITS-1:0];
            end
            if (start && !busy)
                apply_request(req);
            waiting = expected_samples.size();
        end
    end

endmodule

// ===== sim/tb_fractional_circular_shift.sv =====
`timescale 1ns / 1ps

module tb_fractional_circular_shift;

    import fcs_pkg::*;

    localparam int ITEM_TARGET   = 900;
    localparam int SETTLE_CYCLES = 24;
    localparam int CYCLE_LIMIT   = 400000;
    localparam int QUIET_START   = 300;
    localparam int QUIET_END     = 500;

    logic                      clk       = 1'b0;
    logic                      rst_n     = 1'b0;
    logic                      start     = 1'b0;
    req_t                      req       = '0;
    logic                      cfg_write = 1'b0;
    logic [CFG_INDEX_BITS-1:0] cfg_index = '0;
    logic [CFG_DATA_BITS-1:0]  cfg_data  = '0;
    logic                      busy;
    logic                      done;
    result_t                   result;
    int                        fail_count;
    int                        pending_results;
    int                        cycle_count = 0;
    int                        items_sent  = 0;
    int                        first_random;
    int                        kind;
    int                        curve_size;
    int                        whole_pick;
    bit                        gaps_on     = 1'b1;
    logic [FRAC_BITS-1:0]      frac_pick;

    always #2 clk = ~clk;

    fractional_circular_shift u_top (
        .clk       (clk),
        .rst_n     (rst_n),
        .start     (start),
        .busy      (busy),
        .req       (req),
        .done      (done),
        .result    (result),
        .cfg_write (cfg_write),
        .cfg_index (cfg_index),
        .cfg_data  (cfg_data)
    );

    fcs_checker u_checker (
        .clk             (clk),
        .rst_n           (rst_n),
        .start           (start),
        .busy            (busy),
        .req             (req),
        .done            (done),
        .result          (result),
        .cfg_write       (cfg_write),
        .cfg_index       (cfg_index),
        .cfg_data        (cfg_data),
        .fail_count      (fail_count),
        .pending_results (pending_results)
    );

    function automatic logic [SAMPLE_BITS-1:0] random_sample();
        int pick;
        pick = $urandom_range(0, 7);
        if (pick == 0)
            return '0;
        else if (pick == 1)
            return '1;
        return SAMPLE_BITS'($urandom_range(0, (1 << SAMPLE_BITS) - 1));
    endfunction

    function automatic req_t random_request();
        req_t item;
        item.req_type    = 1'($urandom_range(0, 1));
        item.sample      = random_sample();
        item.last_sample = ($urandom_range(0, 5) == 0);
        return item;
    endfunction

    // one transfer, then maybe a random gap with start low
    task automatic drive_item(input req_t item);
        start <= 1'b1;
        req   <= item;
        do
            @(posedge clk);
        while (busy);
        items_sent++;
        @(negedge clk);
        if (gaps_on && $urandom_range(0, 99) < 16)
        begin
            start <= 1'b0;
            req   <= random_request();
            repeat ($urandom_range(1, 12)) @(negedge clk);
        end
    endtask

    task automatic load_sample(input logic [SAMPLE_BITS-1:0] value, input logic is_last);
        req_t item;
        item.req_type    = REQ_LOAD;
        item.sample      = value;
        item.last_sample = is_last;
        drive_item(item);
    endtask

    task automatic issue_output();
        req_t item;
        item             = random_request();
        item.req_type    = REQ_OUTPUT;
        drive_item(item);
    endtask

    // hold off until every expected result is in and the block has settled
    task automatic wait_quiet();
        start <= 1'b0;
        do
            @(negedge clk);
        while (pending_results != 0 || busy);
        repeat (SETTLE_CYCLES) @(negedge clk);
    endtask

    task automatic write_reg(input logic [CFG_INDEX_BITS-1:0] index,
                             input logic [CFG_DATA_BITS-1:0] data);
        cfg_write <= 1'b1;
        cfg_index <= index;
        cfg_data  <= data;
        @(negedge clk);
        cfg_write <= 1'b0;
        @(negedge clk);
    endtask

    task automatic set_shift(input int whole, input logic [FRAC_BITS-1:0] frac);
        write_reg(CFG_SHIFT_WHOLE, CFG_DATA_BITS'(whole));
        write_reg(CFG_SHIFT_FRAC, CFG_DATA_BITS'(frac));
    endtask

    initial
    begin
        while (cycle_count < CYCLE_LIMIT)
        begin
            @(posedge clk);
            cycle_count++;
        end
        $display("simulation failed");
        $finish;
    end

    initial
    begin
        repeat (7) @(posedge clk);
        @(negedge clk);
        rst_n <= 1'b1;
        @(negedge clk);

        // output before any curve is loaded
        issue_output();
        // single-sample curve
        load_sample('1, 1'b1);
        issue_output();
        issue_output();
        wait_quiet();
        set_shift(-1023, '1);
        issue_output();
        load_sample('0, 1'b0);
        load_sample('1, 1'b0);
        load_sample(16'h8001, 1'b1);
        repeat (4) issue_output();
        // reload under way, old length still in force
        load_sample(16'h1234, 1'b0);
        load_sample(16'hABCD, 1'b0);
        repeat (2) issue_output();
        load_sample(16'h5555, 1'b1);
        issue_output();
        wait_quiet();
        set_shift(1023, '0);
        repeat (3) issue_output();
        wait_quiet();
        set_shift(0, 16'h0001);
        issue_output();

        // store overflow ends the curve without a last flag
        wait_quiet();
        set_shift(1000, 16'h8000);
        for (int i = 0; i < MAX_LEN; i++)
            load_sample(random_sample(), 1'b0);
        repeat (40) issue_output();

        first_random = items_sent;
        while (items_sent - first_random < ITEM_TARGET)
        begin
            gaps_on = !(items_sent - first_random >= QUIET_START &&
                        items_sent - first_random < QUIET_END);
            kind = $urandom_range(0, 99);
            if (kind < 12)
            begin
                wait_quiet();
                case ($urandom_range(0, 5))
                    0:       whole_pick = -1023;
                    1:       whole_pick = 1023;
                    2:       whole_pick = 0;
                    default: whole_pick = int'($urandom_range(0, 2046)) - 1023;
                endcase
                case ($urandom_range(0, 4))
                    0:       frac_pick = '0;
                    1:       frac_pick = '1;
                    default: frac_pick = FRAC_BITS'($urandom_range(0, 65535));
                endcase
                set_shift(whole_pick, frac_pick);
            end
            else if (kind < 15)
                wait_quiet();
            else if (kind < 35)
            begin
                repeat ($urandom_range(1, 10)) drive_item(random_request());
            end
            else
            begin
                if ($urandom_range(0, 19) == 0)
                    curve_size = $urandom_range(20, 64);
                else
                    curve_size = $urandom_range(1, 12);
                for (int i = 0; i < curve_size; i++)
                    load_sample(random_sample(), i == curve_size - 1);
                repeat ($urandom_range(1, (2 * curve_size + 1 < 24) ? 2 * curve_size + 1 : 24))
                    issue_output();
            end
        end

        wait_quiet();
        if (fail_count == 0)
            $display("simulation ok");
        else
            $display("simulation failed");
        $finish;
    end

endmodule

// ===== filelist.f =====
rtl/core/fcs_pkg.sv
rtl/core/fcs_ram.sv
rtl/core/fcs_ctrl.sv
rtl/core/fcs_datapath.sv
rtl/core/fractional_circular_shift.sv
sim/fcs_checker.sv
sim/tb_fractional_circular_shift.sv
